>>> rtl/core/yrc_pkg.sv
package yrc_pkg;

  // default size limits
  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;

  // field widths
  localparam int PIX_W     = 8;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int PROD_W    = 17;
  localparam int TERM_W    = 10;
  localparam int SUM_W     = 11;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  // register reset values
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  // chroma offset and output ceiling
  localparam logic [PIX_W-1:0] CHROMA_MID = 8'd128;
  localparam logic [PIX_W-1:0] PIX_MAX    = 8'd255;

  // color matrix coefficients, scaled by 256
  localparam logic signed [8:0] COEF_RV = 9'sd103;
  localparam logic signed [8:0] COEF_GU = 9'sd88;
  localparam logic signed [8:0] COEF_GV = 9'sd183;
  localparam logic signed [8:0] COEF_BU = 9'sd198;

  // chroma contributions shared by both pixels of a macropixel
  typedef struct packed {
    logic signed [TERM_W-1:0] rv;
    logic signed [TERM_W-1:0] gt;
    logic signed [TERM_W-1:0] bu;
  } chroma_terms_t;

  // one converted pixel
  typedef struct packed {
    logic [PIX_W-1:0] b;
    logic [PIX_W-1:0] g;
    logic [PIX_W-1:0] r;
  } bgr_t;

  // position flags of a macropixel
  typedef struct packed {
    logic second_present;
    logic row_end;
    logic frame_end;
  } pos_flags_t;

endpackage

>>> rtl/core/yrc_if.sv
// yuyv macropixel channel
interface yrc_in_if;
  logic                      valid;
  logic                      ready;
  logic [yrc_pkg::PIX_W-1:0] luma_first;
  logic [yrc_pkg::PIX_W-1:0] chroma_blue;
  logic [yrc_pkg::PIX_W-1:0] luma_second;
  logic [yrc_pkg::PIX_W-1:0] chroma_red;

  modport source (output valid, luma_first, chroma_blue, luma_second, chroma_red,
                  input ready);
  modport sink   (input valid, luma_first, chroma_blue, luma_second, chroma_red,
                  output ready);
endinterface

// rgb pixel pair channel
interface yrc_out_if;
  logic                      valid;
  logic                      ready;
  logic [yrc_pkg::PIX_W-1:0] blue_first;
  logic [yrc_pkg::PIX_W-1:0] green_first;
  logic [yrc_pkg::PIX_W-1:0] red_first;
  logic [yrc_pkg::PIX_W-1:0] blue_second;
  logic [yrc_pkg::PIX_W-1:0] green_second;
  logic [yrc_pkg::PIX_W-1:0] red_second;
  logic                      second_present;
  logic                      row_end;
  logic                      frame_end;

  modport source (output valid, blue_first, green_first, red_first, blue_second,
                  green_second, red_second, second_present, row_end, frame_end,
                  input ready);
  modport sink   (input valid, blue_first, green_first, red_first, blue_second,
                  green_second, red_second, second_present, row_end, frame_end,
                  output ready);
endinterface

// register write channel
interface yrc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [yrc_pkg::CFG_IDX_W-1:0] index;
  logic [yrc_pkg::CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/yrc_chroma.sv
module yrc_chroma (
  input  logic [yrc_pkg::PIX_W-1:0] chroma_blue_i,
  input  logic [yrc_pkg::PIX_W-1:0] chroma_red_i,
  output yrc_pkg::chroma_terms_t    terms_o
);

  logic signed [yrc_pkg::PIX_W-1:0]  u;
  logic signed [yrc_pkg::PIX_W-1:0]  v;
  logic signed [yrc_pkg::PROD_W-1:0] p_rv;
  logic signed [yrc_pkg::PROD_W-1:0] p_gu;
  logic signed [yrc_pkg::PROD_W-1:0] p_gv;
  logic signed [yrc_pkg::PROD_W-1:0] p_bu;
  logic signed [8:0]                 t_rv;
  logic signed [8:0]                 t_gu;
  logic signed [8:0]                 t_gv;
  logic signed [8:0]                 t_bu;

  // remove the offset-binary bias
  assign u = $signed(chroma_blue_i - yrc_pkg::CHROMA_MID);
  assign v = $signed(chroma_red_i - yrc_pkg::CHROMA_MID);

  // constant products
  assign p_rv = yrc_pkg::PROD_W'(v) * yrc_pkg::PROD_W'(yrc_pkg::COEF_RV);
  assign p_gu = yrc_pkg::PROD_W'(u) * yrc_pkg::PROD_W'(yrc_pkg::COEF_GU);
  assign p_gv = yrc_pkg::PROD_W'(v) * yrc_pkg::PROD_W'(yrc_pkg::COEF_GV);
  assign p_bu = yrc_pkg::PROD_W'(u) * yrc_pkg::PROD_W'(yrc_pkg::COEF_BU);

  // floor divide by 256 is an arithmetic shift
  assign t_rv = $signed(p_rv[16:8]);
  assign t_gu = $signed(p_gu[16:8]);
  assign t_gv = $signed(p_gv[16:8]);
  assign t_bu = $signed(p_bu[16:8]);

  // per-channel chroma contribution
  assign terms_o.rv = yrc_pkg::TERM_W'(v) + yrc_pkg::TERM_W'(t_rv);
  assign terms_o.gt = -yrc_pkg::TERM_W'(t_gu) - yrc_pkg::TERM_W'(t_gv);
  assign terms_o.bu = yrc_pkg::TERM_W'(u) + yrc_pkg::TERM_W'(t_bu);

endmodule

>>> rtl/core/yrc_lane.sv
module yrc_lane (
  input  logic [yrc_pkg::PIX_W-1:0] luma_i,
  input  yrc_pkg::chroma_terms_t    terms_i,
  output yrc_pkg::bgr_t             pix_o
);

  logic signed [yrc_pkg::SUM_W-1:0] y_ext;
  logic signed [yrc_pkg::SUM_W-1:0] sum_b;
  logic signed [yrc_pkg::SUM_W-1:0] sum_g;
  logic signed [yrc_pkg::SUM_W-1:0] sum_r;

  function automatic logic [yrc_pkg::PIX_W-1:0] sat8(
    input logic signed [yrc_pkg::SUM_W-1:0] x
  );
    logic [yrc_pkg::PIX_W-1:0] res;
    if (x < 0) begin
      res = '0;
    end else if (x > $signed(yrc_pkg::SUM_W'(yrc_pkg::PIX_MAX))) begin
      res = yrc_pkg::PIX_MAX;
    end else begin
      res = x[yrc_pkg::PIX_W-1:0];
    end
    return res;
  endfunction

  // add luma to each chroma term
  assign y_ext = $signed(yrc_pkg::SUM_W'(luma_i));
  assign sum_b = y_ext + yrc_pkg::SUM_W'(terms_i.bu);
  assign sum_g = y_ext + yrc_pkg::SUM_W'(terms_i.gt);
  assign sum_r = y_ext + yrc_pkg::SUM_W'(terms_i.rv);

  // clamp to the pixel range
  assign pix_o.b = sat8(sum_b);
  assign pix_o.g = sat8(sum_g);
  assign pix_o.r = sat8(sum_r);

endmodule

>>> rtl/core/yrc_pos.sv
module yrc_pos #(
  parameter int MAX_WIDTH  = yrc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = yrc_pkg::MAX_HEIGHT_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      advance_i,
  input  logic [yrc_pkg::CFG_W-1:0] frame_width_i,
  input  logic [yrc_pkg::CFG_W-1:0] frame_height_i,
  output yrc_pkg::pos_flags_t       flags_o
);

  localparam int PerRowMax = (MAX_WIDTH + 1) / 2;
  localparam int CW        = $clog2(PerRowMax + 1);
  localparam int RW        = $clog2(MAX_HEIGHT + 1);

  logic [31:0]   w_ext;
  logic [31:0]   h_ext;
  logic [31:0]   w_clip;
  logic [31:0]   h_clip;
  logic [CW-1:0] per_row;
  logic [RW-1:0] rows;
  logic [CW-1:0] col_q, col_d, col_inc;
  logic [RW-1:0] row_q, row_d, row_inc;
  logic          row_end;
  logic          frame_end;

  // clip the geometry to 1..max
  assign w_ext = 32'(frame_width_i);
  assign h_ext = 32'(frame_height_i);

  always_comb begin
    if (w_ext == 32'd0) begin
      w_clip = 32'd1;
    end else if (w_ext > 32'(MAX_WIDTH)) begin
      w_clip = 32'(MAX_WIDTH);
    end else begin
      w_clip = w_ext;
    end
    if (h_ext == 32'd0) begin
      h_clip = 32'd1;
    end else if (h_ext > 32'(MAX_HEIGHT)) begin
      h_clip = 32'(MAX_HEIGHT);
    end else begin
      h_clip = h_ext;
    end
  end

  assign per_row = CW'((w_clip + 32'd1) >> 1);
  assign rows    = RW'(h_clip);

  // end of row and frame detection
  assign col_inc   = col_q + CW'(1);
  assign row_inc   = row_q + RW'(1);
  assign row_end   = col_inc >= per_row;
  assign frame_end = row_end && (row_inc >= rows);

  assign flags_o.row_end        = row_end;
  assign flags_o.frame_end      = frame_end;
  assign flags_o.second_present = !(row_end && w_clip[0]);

  // counter update
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (advance_i) begin
      if (row_end) begin
        col_d = '0;
        row_d = frame_end ? '0 : row_inc;
      end else begin
        col_d = col_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

>>> rtl/core/yuyv_to_rgb24_converter.sv
// Converts a stream of packed YUYV 4:2:2 macropixels to pairs of RGB pixels, one
// macropixel per clock with back-to-back beats. Each beat is accepted while the
// first stage is free to move and moves via stage 1 to the output register;
// the rate is set by the two-stage pipeline (shared chroma multiplies, then two
// parallel pixel lanes with saturation), which advances every cycle the sink
// takes a beat. The position counters mark the last macropixel of each row and
// frame; for an odd frame width the last beat of a row carries only its first
// pixel. Write frame_width and frame_height only while no beat is in flight;
// zero reads as one and values above the size limits saturate to them.
module yuyv_to_rgb24_converter #(
  parameter int MAX_WIDTH  = yrc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = yrc_pkg::MAX_HEIGHT_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  yrc_cfg_if.sink   cfg_i,
  yrc_in_if.sink    pix_i,
  yrc_out_if.source rgb_o
);

  logic [yrc_pkg::CFG_W-1:0] frame_width_q;
  logic [yrc_pkg::CFG_W-1:0] frame_height_q;

  logic                      in_beat;
  logic                      s1_ready;
  logic                      s2_ready;
  logic                      s1_valid_q;
  logic                      out_valid_q;

  yrc_pkg::chroma_terms_t    terms;
  yrc_pkg::pos_flags_t       flags;
  yrc_pkg::chroma_terms_t    terms_q;
  yrc_pkg::pos_flags_t       flags_q;
  logic [yrc_pkg::PIX_W-1:0] y0_q;
  logic [yrc_pkg::PIX_W-1:0] y1_q;

  yrc_pkg::bgr_t             pix_a;
  yrc_pkg::bgr_t             pix_b;
  yrc_pkg::bgr_t             pix_b_gated;
  yrc_pkg::bgr_t             out_a_q;
  yrc_pkg::bgr_t             out_b_q;
  yrc_pkg::pos_flags_t       out_flags_q;

  // register writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= yrc_pkg::FRAME_WIDTH_RST;
      frame_height_q <= yrc_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        yrc_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_i.data;
        yrc_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // pipeline handshake
  assign s2_ready    = !out_valid_q || rgb_o.ready;
  assign s1_ready    = !s1_valid_q || s2_ready;
  assign pix_i.ready = s1_ready;
  assign in_beat     = pix_i.valid && s1_ready;

  // row and frame position
  yrc_pos #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_pos (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .advance_i      (in_beat),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .flags_o        (flags)
  );

  // shared chroma products
  yrc_chroma u_chroma (
    .chroma_blue_i (pix_i.chroma_blue),
    .chroma_red_i  (pix_i.chroma_red),
    .terms_o       (terms)
  );

  // stage 1 registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      terms_q <= terms;
      flags_q <= flags;
      y0_q    <= pix_i.luma_first;
      y1_q    <= pix_i.luma_second;
    end
  end

  // one lane per pixel
  yrc_lane u_lane_a (
    .luma_i  (y0_q),
    .terms_i (terms_q),
    .pix_o   (pix_a)
  );

  yrc_lane u_lane_b (
    .luma_i  (y1_q),
    .terms_i (terms_q),
    .pix_o   (pix_b)
  );

  // merge: drop the second pixel past the row end
  assign pix_b_gated = flags_q.second_present ? pix_b : '0;

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      out_a_q     <= pix_a;
      out_b_q     <= pix_b_gated;
      out_flags_q <= flags_q;
    end
  end

  assign rgb_o.valid          = out_valid_q;
  assign rgb_o.blue_first     = out_a_q.b;
  assign rgb_o.green_first    = out_a_q.g;
  assign rgb_o.red_first      = out_a_q.r;
  assign rgb_o.blue_second    = out_b_q.b;
  assign rgb_o.green_second   = out_b_q.g;
  assign rgb_o.red_second     = out_b_q.r;
  assign rgb_o.second_present = out_flags_q.second_present;
  assign rgb_o.row_end        = out_flags_q.row_end;
  assign rgb_o.frame_end      = out_flags_q.frame_end;

endmodule

>>> tb/yuyv_to_rgb24_converter_tb.sv
`timescale 1ns / 100ps

module yuyv_to_rgb24_converter_tb;
  import yrc_pkg::*;

  localparam int IDLE_PCT       = 34;
  localparam int SETTLE_CYC     = 4;
  localparam int TAIL_CYC       = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RAND_ITEMS     = 1500;
  localparam int MAX_REPORTS    = 10;

  // register indexes outside the map, writes there are dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  typedef struct packed {
    logic [PIX_W-1:0] luma_first;
    logic [PIX_W-1:0] chroma_blue;
    logic [PIX_W-1:0] luma_second;
    logic [PIX_W-1:0] chroma_red;
  } yuyv_t;

  typedef struct packed {
    bgr_t       px0;
    bgr_t       px1;
    pos_flags_t flags;
  } rgb_pair_t;

  logic clk;
  logic rst_n;

  yrc_cfg_if cfg_bus ();
  yrc_in_if  pix_bus ();
  yrc_out_if rgb_bus ();

  yuyv_to_rgb24_converter dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg_bus),
    .pix_i (pix_bus),
    .rgb_o (rgb_bus)
  );

  // macropixels waiting to be sent and pixel pairs waiting to come out
  yuyv_t     yuyv_backlog[$];
  rgb_pair_t pending_rgb[$];

  // shadow of the size registers and position counters
  logic [CFG_W-1:0] width_reg  = FRAME_WIDTH_RST;
  logic [CFG_W-1:0] height_reg = FRAME_HEIGHT_RST;
  int col_pos = 0;
  int row_pos = 0;

  int        n_pix_queued = 0;
  int        n_pix_taken  = 0;
  int        n_bad        = 0;
  int        idle_cycles  = 0;
  int        n_directed;
  int        phase;
  int        n_items;
  bit        calm = 1'b0;
  bit        pix_take;
  bit        busy;
  yuyv_t     next_px;
  rgb_pair_t got_pair;
  rgb_pair_t want_pair;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // floor of coef * d / 256
  function automatic int mul_q8(int coef, int d);
    int prod;
    prod = coef * d;
    return prod >>> 8;
  endfunction

  function automatic logic [PIX_W-1:0] clip8(int x);
    if (x < 0) return '0;
    if (x > int'(PIX_MAX)) return PIX_MAX;
    return PIX_W'(x);
  endfunction

  function automatic bgr_t to_bgr(int y, int u, int v);
    bgr_t p;
    p.r = clip8(y + v + mul_q8(COEF_RV, v));
    p.g = clip8(y - mul_q8(COEF_GU, u) - mul_q8(COEF_GV, v));
    p.b = clip8(y + u + mul_q8(COEF_BU, u));
    return p;
  endfunction

  // zero reads as one, oversize saturates
  function automatic int eff_size(logic [CFG_W-1:0] v, int lim);
    if (v == 0) return 1;
    if (int'(v) > lim) return lim;
    return int'(v);
  endfunction

  // expected pixel pair for one macropixel, advances the position counters
  function automatic rgb_pair_t convert_macropixel(yuyv_t px);
    int w;
    int h;
    int per_row;
    int u;
    int v;
    rgb_pair_t res;
    w       = eff_size(width_reg, MAX_WIDTH_DEF);
    h       = eff_size(height_reg, MAX_HEIGHT_DEF);
    per_row = (w + 1) / 2;
    u       = int'(px.chroma_blue) - int'(CHROMA_MID);
    v       = int'(px.chroma_red) - int'(CHROMA_MID);
    res.flags.row_end        = (col_pos + 1 >= per_row);
    res.flags.frame_end      = res.flags.row_end && (row_pos + 1 >= h);
    res.flags.second_present = !(res.flags.row_end && (w % 2 == 1));
    res.px0 = to_bgr(int'(px.luma_first), u, v);
    res.px1 = res.flags.second_present ? to_bgr(int'(px.luma_second), u, v) : '0;
    if (res.flags.row_end) begin
      col_pos = 0;
      row_pos = res.flags.frame_end ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
    return res;
  endfunction

  task automatic check_field(string name, logic [PIX_W-1:0] want, logic [PIX_W-1:0] got);
    if (got !== want) begin
      n_bad++;
      if (n_bad <= MAX_REPORTS)
        $display("%0t mismatch on %s: expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // bytes lean toward the rails so the clamps get exercised
  function automatic logic [PIX_W-1:0] rand_byte();
    case ($urandom_range(9))
      0: return '0;
      1: return PIX_MAX;
      default: return PIX_W'($urandom_range(255));
    endcase
  endfunction

  function automatic yuyv_t rand_yuyv();
    yuyv_t px;
    px.luma_first  = rand_byte();
    px.chroma_blue = rand_byte();
    px.luma_second = rand_byte();
    px.chroma_red  = rand_byte();
    return px;
  endfunction

  function automatic logic [CFG_W-1:0] pick_width();
    case ($urandom_range(9))
      0: return '0;
      1: return CFG_W'($urandom_range(4096, 8191));
      2: return CFG_W'($urandom_range(17, 200));
      default: return CFG_W'($urandom_range(1, 16));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_height();
    case ($urandom_range(7))
      0: return '0;
      1: return CFG_W'($urandom_range(4096, 8191));
      default: return CFG_W'($urandom_range(1, 6));
    endcase
  endfunction

  task automatic queue_item(yuyv_t px);
    yuyv_backlog.push_back(px);
    n_pix_queued++;
  endtask

  // caller is at a falling edge; valid stays high for a following write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // hold off until every sent macropixel has come back out
  task automatic wait_idle();
    while (n_pix_taken != n_pix_queued || pending_rgb.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  // macropixel sender
  always @(negedge clk) begin
    if (rst_n && (!pix_bus.valid || pix_take)) begin
      if (yuyv_backlog.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        next_px = yuyv_backlog.pop_front();
        pix_bus.luma_first  <= next_px.luma_first;
        pix_bus.chroma_blue <= next_px.chroma_blue;
        pix_bus.luma_second <= next_px.luma_second;
        pix_bus.chroma_red  <= next_px.chroma_red;
        pix_bus.valid       <= 1'b1;
      end else begin
        pix_bus.valid <= 1'b0;
      end
    end
  end

  // output back-pressure
  always @(negedge clk) begin
    if (rst_n) begin
      rgb_bus.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // accepted beats: track registers, predict, compare, watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      pix_take = pix_bus.valid && pix_bus.ready;
      busy     = pix_take;
      if (cfg_bus.valid && cfg_bus.ready) begin
        busy = 1'b1;
        if (cfg_bus.index == REG_FRAME_WIDTH)
          width_reg = cfg_bus.data;
        else if (cfg_bus.index == REG_FRAME_HEIGHT)
          height_reg = cfg_bus.data;
      end
      if (pix_take) begin
        next_px.luma_first  = pix_bus.luma_first;
        next_px.chroma_blue = pix_bus.chroma_blue;
        next_px.luma_second = pix_bus.luma_second;
        next_px.chroma_red  = pix_bus.chroma_red;
        pending_rgb.push_back(convert_macropixel(next_px));
        n_pix_taken++;
      end
      if (rgb_bus.valid && rgb_bus.ready) begin
        busy = 1'b1;
        if (pending_rgb.size() == 0) begin
          n_bad++;
          if (n_bad <= MAX_REPORTS)
            $display("%0t unexpected output beat", $time);
        end else begin
          want_pair = pending_rgb.pop_front();
          check_field("blue_first", want_pair.px0.b, rgb_bus.blue_first);
          check_field("green_first", want_pair.px0.g, rgb_bus.green_first);
          check_field("red_first", want_pair.px0.r, rgb_bus.red_first);
          check_field("blue_second", want_pair.px1.b, rgb_bus.blue_second);
          check_field("green_second", want_pair.px1.g, rgb_bus.green_second);
          check_field("red_second", want_pair.px1.r, rgb_bus.red_second);
          check_field("second_present", PIX_W'(want_pair.flags.second_present),
                      PIX_W'(rgb_bus.second_present));
          check_field("row_end", PIX_W'(want_pair.flags.row_end), PIX_W'(rgb_bus.row_end));
          check_field("frame_end", PIX_W'(want_pair.flags.frame_end),
                      PIX_W'(rgb_bus.frame_end));
        end
      end
      idle_cycles = busy ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[yuyv_to_rgb24_converter] ERROR");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    rst_n               = 1'b0;
    pix_bus.valid       = 1'b0;
    pix_bus.luma_first  = '0;
    pix_bus.chroma_blue = '0;
    pix_bus.luma_second = '0;
    pix_bus.chroma_red  = '0;
    rgb_bus.ready       = 1'b0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.index       = REG_FRAME_WIDTH;
    cfg_bus.data        = '0;
    pix_take            = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset sizes, mid row only
    queue_item({8'd0, 8'd0, 8'd0, 8'd0});
    queue_item({8'd255, 8'd255, 8'd255, 8'd255});
    queue_item({8'd0, 8'd128, 8'd255, 8'd128});
    queue_item({8'd255, 8'd0, 8'd0, 8'd255});
    wait_idle();

    // odd width, two rows: last beat of each row has one pixel
    write_reg(REG_FRAME_WIDTH, 13'd3);
    write_reg(REG_FRAME_HEIGHT, 13'd2);
    cfg_bus.valid <= 1'b0;
    queue_item({8'd0, 8'd255, 8'd255, 8'd0});
    queue_item({8'd255, 8'd0, 8'd255, 8'd0});
    queue_item({8'd0, 8'd0, 8'd255, 8'd255});
    queue_item({8'd128, 8'd128, 8'd128, 8'd128});
    queue_item({8'd16, 8'd128, 8'd235, 8'd128});
    queue_item({8'd235, 8'd240, 8'd16, 8'd16});
    queue_item({8'd0, 8'd127, 8'd255, 8'd129});
    queue_item({8'd255, 8'd129, 8'd0, 8'd127});
    wait_idle();

    // zero sizes read as one
    write_reg(REG_FRAME_WIDTH, 13'd0);
    write_reg(REG_FRAME_HEIGHT, 13'd0);
    cfg_bus.valid <= 1'b0;
    repeat (3) queue_item(rand_yuyv());
    wait_idle();

    // writes outside the register map change nothing
    write_reg(REG_SPARE_LO, 13'd2);
    write_reg(REG_SPARE_HI, 13'h1fff);
    cfg_bus.valid <= 1'b0;
    repeat (3) queue_item(rand_yuyv());
    wait_idle();

    // oversize saturates, then width shrinks under the column counter
    write_reg(REG_FRAME_WIDTH, 13'h1fff);
    write_reg(REG_FRAME_HEIGHT, 13'h1fff);
    cfg_bus.valid <= 1'b0;
    repeat (6) queue_item(rand_yuyv());
    wait_idle();
    write_reg(REG_FRAME_WIDTH, 13'd4);
    cfg_bus.valid <= 1'b0;
    repeat (3) queue_item(rand_yuyv());
    wait_idle();

    // height shrinks under the row counter
    write_reg(REG_FRAME_WIDTH, 13'd2);
    write_reg(REG_FRAME_HEIGHT, 13'd4096);
    cfg_bus.valid <= 1'b0;
    repeat (10) queue_item(rand_yuyv());
    wait_idle();
    write_reg(REG_FRAME_HEIGHT, 13'd3);
    cfg_bus.valid <= 1'b0;
    repeat (4) queue_item(rand_yuyv());
    wait_idle();

    // exact limit and one past it
    write_reg(REG_FRAME_WIDTH, 13'd4096);
    write_reg(REG_FRAME_HEIGHT, 13'd4096);
    cfg_bus.valid <= 1'b0;
    repeat (3) queue_item(rand_yuyv());
    wait_idle();
    write_reg(REG_FRAME_WIDTH, 13'd4097);
    cfg_bus.valid <= 1'b0;
    repeat (2) queue_item(rand_yuyv());

    // random phases, sizes change between them with the pipe drained
    n_directed = n_pix_queued;
    phase      = 0;
    while (n_pix_queued < n_directed + RAND_ITEMS) begin
      wait_idle();
      calm = (phase >= 3 && phase < 6);
      case ($urandom_range(5))
        0: ;
        1: write_reg(REG_FRAME_WIDTH, pick_width());
        2: write_reg(REG_FRAME_HEIGHT, pick_height());
        3: begin
          write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, CFG_W'($urandom));
          write_reg(REG_FRAME_WIDTH, pick_width());
        end
        default: begin
          write_reg(REG_FRAME_HEIGHT, pick_height());
          write_reg(REG_FRAME_WIDTH, pick_width());
        end
      endcase
      cfg_bus.valid <= 1'b0;
      n_items = $urandom_range(20, 150);
      repeat (n_items) queue_item(rand_yuyv());
      phase++;
    end

    calm = 1'b0;
    wait_idle();
    repeat (TAIL_CYC) @(negedge clk);
    if (n_bad == 0 && pending_rgb.size() == 0) begin
      $display("[yuyv_to_rgb24_converter] OK");
    end else begin
      $display("[yuyv_to_rgb24_converter] ERROR");
    end
    $finish;
  end

endmodule
